FILE: src/bmfb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the bit matrix frame buffer.
// No dependencies; imported by every module of the block.
package bmfb_pkg;

    // Command kinds
    localparam logic [3:0] KIND_CLEAR  = 4'd0;
    localparam logic [3:0] KIND_INVERT = 4'd1;
    localparam logic [3:0] KIND_DOT    = 4'd2;
    localparam logic [3:0] KIND_FLIPV  = 4'd3;
    localparam logic [3:0] KIND_FLIPH  = 4'd4;
    localparam logic [3:0] KIND_ROW    = 4'd5;
    localparam logic [3:0] KIND_COL    = 4'd6;
    localparam logic [3:0] KIND_UP     = 4'd7;
    localparam logic [3:0] KIND_DOWN   = 4'd8;
    localparam logic [3:0] KIND_LEFT   = 4'd9;
    localparam logic [3:0] KIND_RIGHT  = 4'd10;
    localparam logic [3:0] KIND_GLYPH  = 4'd11;
    localparam logic [3:0] KIND_READ   = 4'd12;

    // Configuration register indexes and reset values
    localparam logic CFG_ROW_COUNT    = 1'b0;
    localparam logic CFG_COLUMN_BYTES = 1'b1;
    localparam logic [5:0] ROW_COUNT_RST    = 6'd16;
    localparam logic [2:0] COLUMN_BYTES_RST = 3'd2;

    typedef struct packed {
        logic [3:0]  kind;
        logic [4:0]  row;
        logic [4:0]  column;
        logic [31:0] value;
        logic        fill_in;
    } t_req;

    typedef struct packed {
        logic [31:0] row_data;
        logic        accepted;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_TAIL,
        ST_FLIP,
        ST_DONE
    } t_state;

    // Command context handed to the row update logic
    typedef struct packed {
        logic [3:0]  kind;
        logic [4:0]  row;
        logic [4:0]  column;
        logic [31:0] value;
        logic        fill_in;
        logic [31:0] mask;
        logic [31:0] lsb;
        logic [4:0]  gap;
    } t_row_ctl;

    function automatic logic [31:0] reverse32(input logic [31:0] x);
        logic [31:0] y;
        for (int i = 0; i < 32; i++) begin
            y[i] = x[31 - i];
        end
        return y;
    endfunction

endpackage

FILE: src/bmfb_row_alu.sv
`timescale 1ns / 1ps
// Row update logic: new contents of one stored row for per-row commands.
// Depends on bmfb_pkg.
module bmfb_row_alu (
    input  bmfb_pkg::t_row_ctl i_ctl,
    input  logic [31:0]        i_row,
    output logic [31:0]        o_row
);
    import bmfb_pkg::*;

    logic [31:0] pix;
    logic [31:0] x;
    logic [31:0] glyph_m;
    logic [31:0] glyph_d;
    logic        fbit;
    logic        b;

    always_comb begin
        pix     = 32'h8000_0000 >> i_ctl.column;
        fbit    = i_ctl.value[5'd31 - i_ctl.row];
        x       = i_row & i_ctl.mask;
        glyph_m = (32'hFFFF_0000 >> i_ctl.column) & i_ctl.mask;
        glyph_d = {i_ctl.value[15:0], 16'h0000} >> i_ctl.column;
        b       = 1'b0;
        case (i_ctl.kind)
            KIND_CLEAR:  o_row = i_row & ~i_ctl.mask;
            KIND_INVERT: o_row = i_row ^ i_ctl.mask;
            KIND_DOT:    o_row = i_ctl.value[0] ? (i_row | pix) : (i_row & ~pix);
            KIND_COL:    o_row = fbit ? (i_row | pix) : (i_row & ~pix);
            KIND_ROW:    o_row = (i_row & ~i_ctl.mask) | (i_ctl.value & i_ctl.mask);
            KIND_FLIPH: begin
                o_row = (i_row & ~i_ctl.mask)
                      | ((reverse32(x) << i_ctl.gap) & i_ctl.mask);
            end
            KIND_LEFT: begin
                b     = i_ctl.fill_in ? fbit : x[31];
                o_row = (i_row & ~i_ctl.mask) | ((x << 1) & i_ctl.mask)
                      | (b ? i_ctl.lsb : 32'h0);
            end
            KIND_RIGHT: begin
                b     = i_ctl.fill_in ? fbit : (|(x & i_ctl.lsb));
                o_row = (i_row & ~i_ctl.mask) | ((x >> 1) & i_ctl.mask)
                      | (b ? 32'h8000_0000 : 32'h0);
            end
            KIND_GLYPH:  o_row = (i_row & ~glyph_m) | (glyph_d & glyph_m);
            default:     o_row = i_row;
        endcase
    end

endmodule

FILE: src/bit_matrix_frame_buffer.sv
`timescale 1ns / 1ps
// Top level of the bit matrix frame buffer: command sequencer, frame memory.
// Depends on bmfb_pkg and bmfb_row_alu.
//
//   channel   direction  handshake                     payload
//   request   in         i_req_valid / o_req_ready     i_req (t_req)
//   response  out        o_rsp_valid / i_rsp_ready     o_rsp (t_rsp)
//   config    in         i_cfg_we (no handshake back)  i_cfg_index, i_cfg_data
//
// One command at a time. A whole-frame command reads the frame memory once per
// row and writes each row back in the cycle after its read; rotate up/down
// adds a closing write of the last row visited, flip vertical reads and
// writes each pair of rows in turn, and single-row commands touch one row.
// The frame memory has one read port.
// Reset is synchronous; it clears the per-row valid bits, so the frame reads
// as all zero without a clearing pass. A stalled response holds in its
// register and the next command may already run meanwhile.
module bit_matrix_frame_buffer #(
    parameter int MAX_ROWS         = 32,
    parameter int MAX_COLUMN_BYTES = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  bmfb_pkg::t_req  i_req,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    output bmfb_pkg::t_rsp  o_rsp,
    input  logic            i_cfg_we,
    input  logic            i_cfg_index,
    input  logic [5:0]      i_cfg_data
);
    import bmfb_pkg::*;

    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam logic [5:0] MAX_N  = 6'(MAX_ROWS);
    localparam logic [2:0] MAX_CB = 3'(MAX_COLUMN_BYTES);

    // Frame memory and per-row valid bits
    logic [31:0]          mem_rows [MAX_ROWS];
    logic [MAX_ROWS-1:0]  r_valid;
    logic [31:0]          r_mem_q;
    logic                 r_mem_q_ok;

    // Control and command state
    t_state      r_state, n_state;
    logic [5:0]  r_row_count;
    logic [2:0]  r_col_bytes;
    t_req        r_cmd, n_cmd;
    logic [5:0]  r_idx, n_idx;
    logic [5:0]  r_left, n_left;
    logic        r_down, n_down;
    logic        r_rd_pend, n_rd_pend;
    logic [5:0]  r_rd_row, n_rd_row;
    logic        r_first, n_first;
    logic [31:0] r_prev, n_prev;
    logic [5:0]  r_prev_row, n_prev_row;
    logic [31:0] r_save, n_save;
    logic [1:0]  r_phase, n_phase;
    logic [4:0]  r_pair, n_pair;
    logic        r_ok, n_ok;
    logic [31:0] r_data, n_data;
    t_rsp        r_rsp, n_rsp;
    logic        r_rsp_valid, n_rsp_valid;

    // Memory port controls
    logic        rd_en;
    logic [5:0]  rd_addr;
    logic        wr_en;
    logic [5:0]  wr_addr;
    logic [31:0] wr_data;

    // Active area
    logic [5:0]  eff_n;
    logic [2:0]  eff_cb;
    logic [5:0]  eff_w;
    logic [31:0] mask;
    logic [31:0] lsb;
    logic [31:0] cur;
    logic        shift_mode;
    logic [5:0]  lo_row;
    logic [5:0]  hi_row;
    logic        req_fire;

    t_row_ctl    alu_ctl;
    logic [31:0] alu_row;

    // Clamp the registers into their usable ranges
    always_comb begin
        eff_n  = (r_row_count == 6'd0) ? 6'd1 : r_row_count;
        if (eff_n > MAX_N) begin
            eff_n = MAX_N;
        end
        eff_cb = (r_col_bytes == 3'd0) ? 3'd1 : r_col_bytes;
        if (eff_cb > MAX_CB) begin
            eff_cb = MAX_CB;
        end
        eff_w = {eff_cb, 3'b000};
        mask  = ~(32'hFFFF_FFFF >> eff_w);
        lsb   = 32'h8000_0000 >> (eff_w - 6'd1);
    end

    // A never-written row reads as zero
    assign cur        = r_mem_q_ok ? r_mem_q : 32'h0;
    assign shift_mode = (r_cmd.kind == KIND_UP) || (r_cmd.kind == KIND_DOWN);
    assign lo_row     = {1'b0, r_pair};
    assign hi_row     = eff_n - 6'd1 - lo_row;

    assign o_req_ready = (r_state == ST_IDLE);
    assign req_fire    = i_req_valid && o_req_ready;

    // Per-row fill and column bits follow the row being retired
    assign alu_ctl.kind    = r_cmd.kind;
    assign alu_ctl.row     = r_rd_row[4:0];
    assign alu_ctl.column  = r_cmd.column;
    assign alu_ctl.value   = r_cmd.value;
    assign alu_ctl.fill_in = r_cmd.fill_in;
    assign alu_ctl.mask    = mask;
    assign alu_ctl.lsb     = lsb;
    assign alu_ctl.gap     = 5'(6'd32 - eff_w);

    bmfb_row_alu u_alu (
        .i_ctl (alu_ctl),
        .i_row (cur),
        .o_row (alu_row)
    );

    // Sequencer: next state, memory port controls, response
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_left      = r_left;
        n_down      = r_down;
        n_rd_pend   = 1'b0;
        n_rd_row    = r_rd_row;
        n_first     = r_first;
        n_prev      = r_prev;
        n_prev_row  = r_prev_row;
        n_save      = r_save;
        n_phase     = r_phase;
        n_pair      = r_pair;
        n_ok        = r_ok;
        n_data      = r_data;
        n_rsp       = r_rsp;
        n_rsp_valid = r_rsp_valid;
        rd_en       = 1'b0;
        rd_addr     = r_idx;
        wr_en       = 1'b0;
        wr_addr     = r_rd_row;
        wr_data     = alu_row;

        // Drop the response once taken
        if (r_rsp_valid && i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (req_fire) begin
                    n_cmd   = i_req;
                    n_data  = 32'h0;
                    n_ok    = 1'b1;
                    n_idx   = 6'd0;
                    n_left  = eff_n;
                    n_down  = 1'b0;
                    n_first = 1'b1;
                    n_state = ST_SWEEP;
                    case (i_req.kind)
                        KIND_CLEAR, KIND_INVERT, KIND_FLIPH, KIND_LEFT, KIND_RIGHT,
                        KIND_UP: begin
                        end
                        KIND_DOWN: begin
                            n_idx  = eff_n - 6'd1;
                            n_down = 1'b1;
                        end
                        KIND_COL: begin
                            if ({1'b0, i_req.column} >= eff_w) begin
                                n_ok    = 1'b0;
                                n_state = ST_DONE;
                            end
                        end
                        KIND_DOT, KIND_GLYPH: begin
                            n_idx  = {1'b0, i_req.row};
                            n_left = 6'd1;
                            if ({1'b0, i_req.row} >= eff_n ||
                                {1'b0, i_req.column} >= eff_w) begin
                                n_ok    = 1'b0;
                                n_state = ST_DONE;
                            end
                        end
                        KIND_ROW, KIND_READ: begin
                            n_idx  = {1'b0, i_req.row};
                            n_left = 6'd1;
                            if ({1'b0, i_req.row} >= eff_n) begin
                                n_ok    = 1'b0;
                                n_state = ST_DONE;
                            end
                        end
                        KIND_FLIPV: begin
                            n_pair  = 5'd0;
                            n_phase = 2'd0;
                            n_state = (eff_n >= 6'd2) ? ST_FLIP : ST_DONE;
                        end
                        default: begin
                            n_ok    = 1'b0;
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SWEEP: begin
                // Issue the next row read
                if (r_left != 6'd0) begin
                    rd_en     = 1'b1;
                    rd_addr   = r_idx;
                    n_idx     = r_down ? (r_idx - 6'd1) : (r_idx + 6'd1);
                    n_left    = r_left - 6'd1;
                    n_rd_pend = 1'b1;
                    n_rd_row  = r_idx;
                end
                // Retire the row read issued in the previous cycle
                if (r_rd_pend) begin
                    if (shift_mode) begin
                        if (r_first) begin
                            n_save  = cur;
                            n_first = 1'b0;
                        end else begin
                            wr_en   = 1'b1;
                            wr_addr = r_prev_row;
                            wr_data = (r_prev & ~mask) | (cur & mask);
                        end
                        n_prev     = cur;
                        n_prev_row = r_rd_row;
                    end else if (r_cmd.kind == KIND_READ) begin
                        n_data = cur & mask;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = r_rd_row;
                        wr_data = alu_row;
                    end
                    if (r_left == 6'd0) begin
                        n_state = shift_mode ? ST_TAIL : ST_DONE;
                    end
                end
            end

            ST_TAIL: begin
                // Close the rotation: last row visited takes fill or wrap
                wr_en   = 1'b1;
                wr_addr = r_prev_row;
                wr_data = (r_prev & ~mask)
                        | ((r_cmd.fill_in ? r_cmd.value : r_save) & mask);
                n_state = ST_DONE;
            end

            ST_FLIP: begin
                n_phase = r_phase + 2'd1;
                case (r_phase)
                    2'd0: begin
                        rd_en   = 1'b1;
                        rd_addr = lo_row;
                    end
                    2'd1: begin
                        n_prev  = cur;
                        rd_en   = 1'b1;
                        rd_addr = hi_row;
                    end
                    2'd2: begin
                        n_save  = cur;
                        wr_en   = 1'b1;
                        wr_addr = lo_row;
                        wr_data = (r_prev & ~mask) | (cur & mask);
                    end
                    default: begin
                        wr_en   = 1'b1;
                        wr_addr = hi_row;
                        wr_data = (r_save & ~mask) | (r_prev & mask);
                        n_pair  = r_pair + 5'd1;
                        if ((lo_row + 6'd1) >= (eff_n >> 1)) begin
                            n_state = ST_DONE;
                        end
                    end
                endcase
            end

            ST_DONE: begin
                // Hold until the response register is free
                if (!r_rsp_valid || i_rsp_ready) begin
                    n_rsp.row_data = r_data;
                    n_rsp.accepted = r_ok;
                    n_rsp_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rsp_valid <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_row_count <= ROW_COUNT_RST;
            r_col_bytes <= COLUMN_BYTES_RST;
            r_valid     <= '0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
            r_rd_pend   <= n_rd_pend;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ROW_COUNT:    r_row_count <= i_cfg_data;
                    CFG_COLUMN_BYTES: r_col_bytes <= i_cfg_data[2:0];
                    default:          r_row_count <= r_row_count;
                endcase
            end
            if (wr_en) begin
                r_valid[wr_addr[AW-1:0]] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_idx      <= n_idx;
        r_left     <= n_left;
        r_down     <= n_down;
        r_rd_row   <= n_rd_row;
        r_first    <= n_first;
        r_prev     <= n_prev;
        r_prev_row <= n_prev_row;
        r_save     <= n_save;
        r_phase    <= n_phase;
        r_pair     <= n_pair;
        r_ok       <= n_ok;
        r_data     <= n_data;
        r_rsp      <= n_rsp;
    end

    // Frame memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_rows[wr_addr[AW-1:0]] <= wr_data;
        end
        if (rd_en) begin
            r_mem_q    <= mem_rows[rd_addr[AW-1:0]];
            r_mem_q_ok <= r_valid[rd_addr[AW-1:0]];
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

FILE: src/bmfb_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the bit matrix frame buffer, bound to the top level.
// Depends on bmfb_pkg and bit_matrix_frame_buffer.
module bmfb_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_req_valid,
    input logic            o_req_ready,
    input logic            o_rsp_valid,
    input logic            i_rsp_ready,
    input bmfb_pkg::t_rsp  o_rsp
);
    import bmfb_pkg::*;

    // One command in flight: ready drops right after a request is taken
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> !o_req_ready)
        else $error("request taken while a command is still running");

    // A rejected command never returns row data
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_rsp.accepted) |-> (o_rsp.row_data == 32'h0))
        else $error("rejected command returned row data");

    // A stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !i_rsp_ready) |=> (o_rsp_valid && $stable(o_rsp)))
        else $error("stalled response changed or dropped");

    // Reset empties the response register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid)
        else $error("response valid right after reset");

endmodule

bind bit_matrix_frame_buffer bmfb_checker u_bmfb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_ready (o_req_ready),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_ready (i_rsp_ready),
    .o_rsp       (o_rsp)
);
